@@ rtl/urxcrlf_pkg.sv @@
`default_nettype none

package urxcrlf_pkg;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_READ    = 2'd1,
      OP_RELEASE = 2'd2
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_BIT_PERIOD   = 1'b0,
      CSR_FIRST_SAMPLE = 1'b1
   } csr_index_type;

   localparam logic [7:0]  CHAR_LF            = 8'h0a;
   localparam logic [7:0]  CHAR_CR            = 8'h0d;
   localparam logic [3:0]  NUM_SAMPLES        = 4'd9;
   localparam logic [15:0] BIT_PERIOD_RESET   = 16'd104;
   localparam logic [15:0] FIRST_SAMPLE_RESET = 16'd30;

   typedef struct packed {
      logic [1:0] opcode;
      logic       rx_level;
      logic [7:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic       byte_done;
      logic [7:0] rx_byte;
      logic       line_ready;
      logic       cr_pending;
      logic [7:0] line_length;
      logic [7:0] read_data;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/urxcrlf_chan_if.sv @@
`default_nettype none

interface urxcrlf_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/uart_rx_crlf_line_assembler.sv @@
// channel   dir  payload                                              accept
// req_chan  in   opcode[1:0] rx_level read_index[7:0]                  valid & ready
// rsp_chan  out  byte_done rx_byte line_ready cr_pending
//                line_length read_data                                valid & ready
// csr_*     in   csr_index selects register, csr_wdata[15:0]          csr_we
//
// one word per cycle while rsp_chan takes results; each result passes the read stage, then the output register
// the line buffer memory has one registered read port, so reads take a stage
// synchronous active high reset clears control state only; the buffer is not cleared
// a stalled result holds the output register; one more word waits in the read stage,
// then req_chan.ready drops until rsp_chan.ready returns
`default_nettype none

module uart_rx_crlf_line_assembler #(
   parameter int LINE_BUFFER_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   urxcrlf_chan_if.sink     req_chan,
   urxcrlf_chan_if.source   rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int AW = (LINE_BUFFER_DEPTH > 1) ? $clog2(LINE_BUFFER_DEPTH) : 1;
   localparam int IW = (AW > 8) ? AW : 8;
   localparam int CW = IW + 1;

   logic [15:0]   bit_period_ff, bit_period_in;
   logic [15:0]   first_sample_ff, first_sample_in;
   logic          prev_level_ff, prev_level_in;
   logic          receiving_ff, receiving_in;
   logic [15:0]   tick_count_ff, tick_count_in;
   logic [3:0]    sample_count_ff, sample_count_in;
   logic [7:0]    shift_byte_ff, shift_byte_in;
   logic          line_done_ff, line_done_in;
   logic          cr_ff, cr_in;
   logic [AW-1:0] count_ff, count_in;

   logic [7:0]    line_store [LINE_BUFFER_DEPTH];
   logic [7:0]    mem_q_ff;

   logic                       s1_valid_ff, s1_valid_in;
   urxcrlf_pkg::rsp_word_type  s1_word_ff, s1_word_in;
   logic                       s1_read_ff, s1_read_in;
   logic                       out_valid_ff, out_valid_in;
   urxcrlf_pkg::rsp_word_type  out_word_ff, out_word_in;

   urxcrlf_pkg::req_word_type req;
   logic          accept, s1_advance;
   logic          is_tick, is_read, is_release;
   logic [15:0]   target, tick_next;
   logic          done;
   logic          mem_we, mem_re;
   logic [AW-1:0] rd_addr;
   logic          rd_in_range;
   logic [AW:0]   count_inc;

   assign req        = req_chan.payload;
   assign s1_advance = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept     = req_chan.valid && req_chan.ready;
   assign is_tick    = accept && (req.opcode == urxcrlf_pkg::OP_TICK);
   assign is_read    = accept && (req.opcode == urxcrlf_pkg::OP_READ);
   assign is_release = accept && (req.opcode == urxcrlf_pkg::OP_RELEASE);

   assign target    = (sample_count_ff == 4'd0) ? first_sample_ff : bit_period_ff;
   assign tick_next = tick_count_ff + 16'd1;
   assign count_inc = {1'b0, count_ff} + {{AW{1'b0}}, 1'b1};

   assign rd_in_range = CW'(req.read_index) < CW'(LINE_BUFFER_DEPTH);
   assign rd_addr     = AW'(req.read_index);

   always_comb begin
      bit_period_in   = bit_period_ff;
      first_sample_in = first_sample_ff;
      if (csr_we) begin
         case (csr_index)
            urxcrlf_pkg::CSR_BIT_PERIOD:   bit_period_in   = csr_wdata;
            urxcrlf_pkg::CSR_FIRST_SAMPLE: first_sample_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      prev_level_in   = prev_level_ff;
      receiving_in    = receiving_ff;
      tick_count_in   = tick_count_ff;
      sample_count_in = sample_count_ff;
      shift_byte_in   = shift_byte_ff;
      line_done_in    = line_done_ff;
      cr_in           = cr_ff;
      count_in        = count_ff;
      done            = 1'b0;
      mem_we          = 1'b0;
      if (is_tick) begin
         prev_level_in = req.rx_level;
         if (!receiving_ff) begin
            if (prev_level_ff && !req.rx_level) begin
               receiving_in    = 1'b1;
               tick_count_in   = 16'd0;
               sample_count_in = 4'd0;
            end
         end else begin
            tick_count_in = tick_next;
            if (tick_next >= target) begin
               tick_count_in = 16'd0;
               if (sample_count_ff < urxcrlf_pkg::NUM_SAMPLES) begin
                  shift_byte_in   = {req.rx_level, shift_byte_ff[7:1]};
                  sample_count_in = sample_count_ff + 4'd1;
               end else begin
                  receiving_in    = 1'b0;
                  sample_count_in = 4'd0;
                  done            = 1'b1;
               end
            end
         end
      end
      if (done && !line_done_ff) begin
         if (cr_ff) begin
            if (shift_byte_ff != urxcrlf_pkg::CHAR_LF) begin
               cr_in    = 1'b0;
               count_in = '0;
            end else begin
               line_done_in = 1'b1;
            end
         end else if (shift_byte_ff == urxcrlf_pkg::CHAR_CR) begin
            cr_in = 1'b1;
         end else begin
            mem_we = 1'b1;
            if (count_inc == (AW+1)'(LINE_BUFFER_DEPTH)) begin
               count_in = '0;
            end else begin
               count_in = count_inc[AW-1:0];
            end
         end
      end
      if (is_release) begin
         line_done_in = 1'b0;
         cr_in        = 1'b0;
         count_in     = '0;
      end
   end

   assign mem_re = is_read && rd_in_range;

   // buffer memory, one write or one registered read per word
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store[count_ff] <= shift_byte_ff;
      end
      if (mem_re) begin
         mem_q_ff <= line_store[rd_addr];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s1_read_in  = s1_read_ff;
      if (accept) begin
         s1_valid_in            = 1'b1;
         s1_word_in.byte_done   = done;
         s1_word_in.rx_byte     = done ? shift_byte_ff : 8'd0;
         s1_word_in.line_ready  = line_done_in;
         s1_word_in.cr_pending  = cr_in;
         s1_word_in.line_length = 8'(count_in);
         s1_word_in.read_data   = 8'd0;
         s1_read_in             = mem_re;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (s1_advance) begin
         out_valid_in          = s1_valid_ff;
         out_word_in           = s1_word_ff;
         out_word_in.read_data = s1_read_ff ? mem_q_ff : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff   <= urxcrlf_pkg::BIT_PERIOD_RESET;
         first_sample_ff <= urxcrlf_pkg::FIRST_SAMPLE_RESET;
         prev_level_ff   <= 1'b1;
         receiving_ff    <= 1'b0;
         tick_count_ff   <= 16'd0;
         sample_count_ff <= 4'd0;
         shift_byte_ff   <= 8'd0;
         line_done_ff    <= 1'b0;
         cr_ff           <= 1'b0;
         count_ff        <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         bit_period_ff   <= bit_period_in;
         first_sample_ff <= first_sample_in;
         prev_level_ff   <= prev_level_in;
         receiving_ff    <= receiving_in;
         tick_count_ff   <= tick_count_in;
         sample_count_ff <= sample_count_in;
         shift_byte_ff   <= shift_byte_in;
         line_done_ff    <= line_done_in;
         cr_ff           <= cr_in;
         count_ff        <= count_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      s1_read_ff  <= s1_read_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

`ifndef ASSERT_OFF
   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !receiving_ff |-> (tick_count_ff == 16'd0) && (sample_count_ff == 4'd0))
      else $error("receiver idle with nonzero counters");
   a_sample_bound: assert property (@(posedge clock) disable iff (reset)
      sample_count_ff <= urxcrlf_pkg::NUM_SAMPLES)
      else $error("sample count beyond stop bit");
   a_line_needs_cr: assert property (@(posedge clock) disable iff (reset)
      line_done_ff |-> cr_ff)
      else $error("line ready without cr pending");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |-> !accept)
      else $error("word accepted while read stage is stalled");
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_word_ff.byte_done) |-> (out_word_ff.rx_byte == 8'd0))
      else $error("rx_byte nonzero without byte_done");
`endif

endmodule

`default_nettype wire

@@ bench/tb_uart_rx_crlf_line_assembler.sv @@
`timescale 1ns / 100ps

module tb_uart_rx_crlf_line_assembler;

   localparam int          LINE_DEPTH     = 256;
   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam int          ITEM_TARGET    = 450;
   localparam int          HOLD_AT        = 120;
   localparam int          HOLD_BACKLOG   = 16;
   localparam int          LONG_HOLD      = 300;
   localparam int          WATCHDOG_LIMIT = 2000;

   typedef struct {
      urxcrlf_pkg::req_word_type word;
      urxcrlf_pkg::rsp_word_type status;
   } line_item_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;

   urxcrlf_chan_if #(.payload_type(urxcrlf_pkg::req_word_type)) req_if ();
   urxcrlf_chan_if #(.payload_type(urxcrlf_pkg::rsp_word_type)) rsp_if ();

   uart_rx_crlf_line_assembler #(
      .LINE_BUFFER_DEPTH(LINE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver and line buffer prediction
   logic [15:0] cfg_bit_period   = urxcrlf_pkg::BIT_PERIOD_RESET;
   logic [15:0] cfg_first_sample = urxcrlf_pkg::FIRST_SAMPLE_RESET;
   logic        rx_prev_level    = 1'b1;
   logic        rx_busy          = 1'b0;
   logic [15:0] rx_ticks         = '0;
   logic [3:0]  rx_samples       = '0;
   logic [7:0]  rx_shift         = '0;
   logic        line_held        = 1'b0;
   logic        line_cr          = 1'b0;
   int unsigned line_count       = 0;
   logic [7:0]  line_mem [LINE_DEPTH];
   bit          line_written [LINE_DEPTH];
   int unsigned written_total    = 0;
   int unsigned items_queued     = 0;

   line_item_type             pending_words[$];
   urxcrlf_pkg::rsp_word_type expected_status[$];
   urxcrlf_pkg::rsp_word_type sent_status;
   urxcrlf_pkg::rsp_word_type want;

   logic        req_fire = 1'b0;
   logic        rsp_fire = 1'b0;
   int unsigned send_gap = 0;
   int unsigned send_burst = 0;
   int unsigned sink_wait = 0;
   int unsigned sink_burst = 0;
   int unsigned sink_draw = 0;
   bit          hold_done = 1'b0;
   int unsigned results_seen = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   line_item_type next_item;

   function automatic void take_rx_byte(input logic [7:0] b);
      if (line_held)
         return;
      if (line_cr) begin
         if (b != urxcrlf_pkg::CHAR_LF) begin
            line_cr = 1'b0;
            line_count = 0;
         end else begin
            line_held = 1'b1;
         end
      end else if (b == urxcrlf_pkg::CHAR_CR) begin
         line_cr = 1'b1;
      end else begin
         line_mem[line_count] = b;
         if (!line_written[line_count]) begin
            line_written[line_count] = 1'b1;
            written_total++;
         end
         line_count = (line_count + 1 >= LINE_DEPTH) ? 0 : line_count + 1;
      end
   endfunction

   function automatic urxcrlf_pkg::rsp_word_type assemble_step(
      input urxcrlf_pkg::req_word_type w);
      urxcrlf_pkg::rsp_word_type s;
      logic [15:0]               target;
      s = '0;
      case (w.opcode)
         urxcrlf_pkg::OP_TICK: begin
            if (!rx_busy) begin
               if (rx_prev_level && !w.rx_level) begin
                  rx_busy = 1'b1;
                  rx_ticks = '0;
                  rx_samples = '0;
               end
            end else begin
               target = (rx_samples == 0) ? cfg_first_sample : cfg_bit_period;
               rx_ticks = rx_ticks + 16'd1;
               if (rx_ticks >= target) begin
                  rx_ticks = '0;
                  if (rx_samples < urxcrlf_pkg::NUM_SAMPLES) begin
                     rx_shift = {w.rx_level, rx_shift[7:1]};
                     rx_samples = rx_samples + 4'd1;
                  end else begin
                     rx_busy = 1'b0;
                     rx_samples = '0;
                     s.byte_done = 1'b1;
                     s.rx_byte = rx_shift;
                     take_rx_byte(rx_shift);
                  end
               end
            end
            rx_prev_level = w.rx_level;
         end
         urxcrlf_pkg::OP_READ: begin
            if (int'(w.read_index) < LINE_DEPTH)
               s.read_data = line_mem[w.read_index];
         end
         urxcrlf_pkg::OP_RELEASE: begin
            line_held = 1'b0;
            line_cr = 1'b0;
            line_count = 0;
         end
         default: begin
         end
      endcase
      s.line_ready = line_held;
      s.cr_pending = line_cr;
      s.line_length = 8'(line_count);
      return s;
   endfunction

   function automatic void queue_word(input logic [1:0] op, input logic level,
                                      input logic [7:0] index);
      line_item_type it;
      it.word.opcode = op;
      it.word.rx_level = level;
      it.word.read_index = index;
      it.status = assemble_step(it.word);
      pending_words.push_back(it);
      items_queued++;
   endfunction

   function automatic void queue_tick(input logic level);
      queue_word(urxcrlf_pkg::OP_TICK, level, 8'($urandom));
   endfunction

   function automatic void queue_read();
      logic [7:0] idx;
      if (written_total == 0)
         return;
      do
         idx = 8'($urandom);
      while (!line_written[idx]);
      queue_word(urxcrlf_pkg::OP_READ, 1'($urandom), idx);
   endfunction

   function automatic void queue_op(input logic [1:0] op);
      queue_word(op, 1'($urandom), 8'($urandom));
   endfunction

   // frame bits from_bit to stop; noisy frames drive random levels between sample points
   function automatic void send_bits(input logic [7:0] b, input bit noisy,
                                     input int from_bit);
      logic        lvl;
      int unsigned span;
      for (int k = from_bit; k < 10; k++) begin
         lvl = (k == 0) ? 1'b0 : (k == 9) ? 1'b1 : b[k - 1];
         span = (k == 0) ? cfg_first_sample : cfg_bit_period;
         for (int unsigned n = 1; n <= span; n++)
            queue_tick((n == span || !noisy) ? lvl : 1'($urandom));
      end
   endfunction

   // one 8n1 frame
   function automatic void send_byte(input logic [7:0] b, input bit noisy);
      while (rx_busy)
         queue_tick(1'b1);
      queue_tick(1'b1);
      queue_tick(1'b0);
      send_bits(b, noisy, 0);
   endfunction

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (b == urxcrlf_pkg::CHAR_CR);
      return b;
   endfunction

   function automatic int unsigned gap_draw(inout int unsigned burst_left);
      if (burst_left != 0) begin
         burst_left = burst_left - 1;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   task automatic check_field(input string field, input logic [7:0] exp_val,
                              input logic [7:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, exp_val, got_val);
         error_count++;
      end
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_words.size() != 0 || req_if.valid || expected_status.size() != 0);
   endtask

   task automatic csr_write(input urxcrlf_pkg::csr_index_type idx,
                            input logic [15:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == urxcrlf_pkg::CSR_BIT_PERIOD)
         cfg_bit_period = value;
      else
         cfg_first_sample = value;
   endtask

   // word driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap <= 0;
      end else if (req_if.valid && !req_fire) begin
      end else if (send_gap != 0) begin
         req_if.valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_words.size() != 0) begin
         next_item = pending_words.pop_front();
         req_if.payload <= next_item.word;
         sent_status <= next_item.status;
         req_if.valid <= 1'b1;
         send_gap <= gap_draw(send_burst);
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // result sink with one long hold-off while the sender still has words
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         sink_wait <= 0;
      end else if (rsp_fire && !hold_done && results_seen >= HOLD_AT &&
                   pending_words.size() >= HOLD_BACKLOG) begin
         rsp_if.ready <= 1'b0;
         sink_wait <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (rsp_fire) begin
         sink_draw = gap_draw(sink_burst);
         rsp_if.ready <= (sink_draw == 0);
         sink_wait <= sink_draw;
      end else if (sink_wait != 0) begin
         rsp_if.ready <= (sink_wait == 1);
         sink_wait <= sink_wait - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_if.valid && req_if.ready;
      rsp_fire <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual 0x%0h",
                     $time, rsp_if.payload);
            error_count++;
         end else begin
            want = expected_status.pop_front();
            check_field("byte_done", want.byte_done, rsp_if.payload.byte_done);
            check_field("rx_byte", want.rx_byte, rsp_if.payload.rx_byte);
            check_field("line_ready", want.line_ready, rsp_if.payload.line_ready);
            check_field("cr_pending", want.cr_pending, rsp_if.payload.cr_pending);
            check_field("line_length", want.line_length, rsp_if.payload.line_length);
            check_field("read_data", want.read_data, rsp_if.payload.read_data);
         end
      end
      if (!reset && req_if.valid && req_if.ready)
         expected_status.push_back(sent_status);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("** uart_rx_crlf_line_assembler: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = urxcrlf_pkg::CSR_BIT_PERIOD;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset start sample timing, short bit period
      csr_write(urxcrlf_pkg::CSR_BIT_PERIOD, 16'd2);
      send_byte(8'hA5, 1'b0);
      queue_word(urxcrlf_pkg::OP_READ, 1'b0, 8'd0);
      queue_op(OP_UNUSED);
      queue_op(urxcrlf_pkg::OP_RELEASE);

      // largest start sample period, cut short mid frame
      csr_write(urxcrlf_pkg::CSR_FIRST_SAMPLE, 16'hFFFF);
      queue_tick(1'b1);
      queue_tick(1'b0);
      repeat (40) queue_tick(1'b0);
      csr_write(urxcrlf_pkg::CSR_FIRST_SAMPLE, 16'd1);
      queue_tick(1'b0);
      send_bits(8'h3C, 1'b0, 1);

      // line end, drop while held, discards after cr
      send_byte(8'h41, 1'b0);
      send_byte(urxcrlf_pkg::CHAR_CR, 1'b0);
      send_byte(urxcrlf_pkg::CHAR_LF, 1'b1);
      send_byte(8'h41, 1'b1);
      queue_word(urxcrlf_pkg::OP_READ, 1'b1, 8'd0);
      queue_word(urxcrlf_pkg::OP_READ, 1'b0, 8'd1);
      queue_op(OP_UNUSED);
      queue_op(urxcrlf_pkg::OP_RELEASE);
      send_byte(urxcrlf_pkg::CHAR_CR, 1'b0);
      send_byte(8'h42, 1'b1);
      send_byte(urxcrlf_pkg::CHAR_CR, 1'b0);
      send_byte(urxcrlf_pkg::CHAR_CR, 1'b0);
      send_byte(8'hFF, 1'b0);
      queue_op(urxcrlf_pkg::OP_RELEASE);

      // random traffic
      csr_write(urxcrlf_pkg::CSR_BIT_PERIOD, 16'($urandom_range(2, 3)));
      csr_write(urxcrlf_pkg::CSR_FIRST_SAMPLE, 16'($urandom_range(1, 4)));
      while (items_queued < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0, 1: send_byte(text_byte(), $urandom_range(0, 3) == 0);
            2: begin
               send_byte(urxcrlf_pkg::CHAR_CR, $urandom_range(0, 3) == 0);
               send_byte(urxcrlf_pkg::CHAR_LF, $urandom_range(0, 3) == 0);
            end
            3: send_byte(8'($urandom), 1'b0);
            4: queue_read();
            5: queue_op(urxcrlf_pkg::OP_RELEASE);
            6: queue_op(OP_UNUSED);
            default: repeat ($urandom_range(1, 6)) queue_tick(1'($urandom));
         endcase
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_status.size() == 0)
         $display("** uart_rx_crlf_line_assembler: PASSED **");
      else
         $display("** uart_rx_crlf_line_assembler: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
rtl/urxcrlf_pkg.sv
rtl/urxcrlf_chan_if.sv
rtl/uart_rx_crlf_line_assembler.sv
bench/tb_uart_rx_crlf_line_assembler.sv
